// File: design/assert_macros.svh
// Assertion macros shared by the warp RTL.
// Included by modules that check their own pipeline; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on clk, disabled while rst_n is low
`define RLWB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included
`define RLWB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLWB_ASSERT(label, prop, msg)
`define RLWB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/rlwb_pkg.sv
// Shared types and constants for the radial lens warp block.
// No dependencies; imported by radial_lens_warp_bilinear and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package rlwb_pkg;

    // Request kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_DISTORTION_GAIN = 2'd2
    } cfg_reg_t;

    localparam int SIZE_W    = 9;
    localparam int GAIN_W    = 41;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;

    // Input request
    typedef struct packed {
        logic        req_type;
        logic [7:0]  pixel_col;
        logic [7:0]  pixel_row;
        logic [31:0] source_rgba;
    } in_req_t;

    // Interpolated pixel
    typedef struct packed {
        logic [7:0] chan3_value;
        logic [7:0] chan2_value;
        logic [7:0] chan1_value;
        logic [7:0] chan0_value;
    } out_pix_t;

    // Write request traveling to the frame store stage
    typedef struct packed {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] rgba;
    } wr_pipe_t;

endpackage

`default_nettype wire

// File: design/rlwb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rlwb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/radial_lens_warp_bilinear.sv
// Radial lens warp with bilinear resampling: top level, pipeline and frame store.
// Depends on rlwb_pkg, rlwb_ram and assert_macros.svh.
// A render result strobes on result_valid from the output register behind stage 11.
// Throughput: one request per clock, writes and renders alike; busy is always low.
// The frame store is four parity banks, each with its own read port, so all four
// bilinear neighbors are read in the same cycle. Reset clears control and config only;
// store contents are undefined until written. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module radial_lens_warp_bilinear #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire rlwb_pkg::in_req_t                   req,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rlwb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rlwb_pkg::GAIN_W-1:0]         cfg_data,
    output logic                                     result_valid,
    output rlwb_pkg::out_pix_t                       result
);

    import rlwb_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = (WW > HW) ? WW : HW;
    localparam int BASEW = (SW > 9) ? SW : 9;
    localparam int DW    = BASEW + 2;          // signed half-pixel offset
    localparam int R2W   = 2 * DW;             // squared radius
    localparam int GL_W  = 20;
    localparam int GH_W  = GAIN_W - GL_W;
    localparam int PL_W  = GL_W + R2W;
    localparam int PH_W  = GH_W + R2W + 1;
    localparam int PROD_W = GAIN_W + R2W + 1;  // gain times r2, signed
    localparam int SFW   = PROD_W - 9;         // unsaturated scale
    localparam int MXW   = DW + 32;            // offset times scale
    localparam int SXW   = MXW - 14;           // source position, 16 fraction bits
    localparam int XW    = SXW - FRAC_W;       // integer source coordinate
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int CAW   = (CB > 1) ? CB - 1 : 1;
    localparam int RAW   = (RB > 1) ? RB - 1 : 1;
    localparam int BAW   = CAW + RAW;
    localparam int BANK_DEPTH = 1 << BAW;
    localparam int WT_W  = FRAC_W + 1;         // one-axis weight
    localparam int WGT_W = 2 * FRAC_W + 1;     // neighbor weight
    localparam int PRD_W = WGT_W + 8;
    localparam int SUM_W = PRD_W + 2;

    localparam logic signed [SFW-1:0] SC_ONE = SFW'(1) <<< 30;
    localparam logic signed [SFW-1:0] SC_MAX = (SFW'(1) <<< 31) - SFW'(1);
    localparam logic signed [SFW-1:0] SC_MIN = -(SFW'(1) <<< 31);

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0]        width_reg;
    logic [SIZE_W-1:0]        height_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(256);
            height_reg <= SIZE_W'(256);
            gain_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:     width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT:    height_reg <= cfg_data[SIZE_W-1:0];
                CFG_DISTORTION_GAIN: gain_reg   <= $signed(cfg_data);
                default:             ;
            endcase
        end
    end

    // Effective frame size, clamped to [1, MAX]
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = SW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = SW'(MAX_WIDTH);
        else
            w_eff = SW'(width_reg);
        if (height_reg == '0)
            h_eff = SW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = SW'(MAX_HEIGHT);
        else
            h_eff = SW'(height_reg);
    end

    // ---------------- control: valid bits per stage ----------------
    logic        accept;
    logic [8:1]  wr_vld_reg;
    logic [11:1] rd_vld_reg;
    logic        result_valid_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_vld_reg       <= '0;
            rd_vld_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            wr_vld_reg       <= {wr_vld_reg[7:1], accept && (req.req_type == REQ_WRITE)};
            rd_vld_reg       <= {rd_vld_reg[10:1], accept && (req.req_type == REQ_RENDER)};
            result_valid_reg <= rd_vld_reg[11];
        end
    end

    assign result_valid = result_valid_reg;

    // ---------------- payload pipeline ----------------
    wr_pipe_t                 wr_pipe_reg [1:8];
    logic signed [DW-1:0]     dx_pipe_reg [1:6];
    logic signed [DW-1:0]     dy_pipe_reg [1:6];
    logic [R2W-1:0]           sqx_s2_reg, sqy_s2_reg;
    logic [R2W-1:0]           r2_s3_reg;
    logic [PL_W-1:0]          pl_s4_reg;
    logic signed [PH_W-1:0]   ph_s4_reg;
    logic signed [PROD_W-1:0] p_s5_reg;
    logic signed [31:0]       scale_s6_reg;
    logic signed [MXW-1:0]    mx_s7_reg, my_s7_reg;
    logic signed [SXW-1:0]    sx_s8_reg, sy_s8_reg;

    // Stage 1: half-pixel offsets from the centre
    logic signed [DW-1:0] dx_next, dy_next;
    assign dx_next = $signed(DW'({req.pixel_col, 1'b1}) - DW'(w_eff));
    assign dy_next = $signed(DW'({req.pixel_row, 1'b1}) - DW'(h_eff));

    // Stage 2..3: squared radius
    logic signed [R2W-1:0] sqx_full, sqy_full;
    assign sqx_full = dx_pipe_reg[1] * dx_pipe_reg[1];
    assign sqy_full = dy_pipe_reg[1] * dy_pipe_reg[1];

    // Stage 4: gain times r2 as two partial products
    logic [PL_W-1:0]        pl_next;
    logic signed [PH_W-1:0] ph_next;
    assign pl_next = gain_reg[GL_W-1:0] * r2_s3_reg;
    assign ph_next = $signed(gain_reg[GAIN_W-1:GL_W]) * $signed({1'b0, r2_s3_reg});

    // Stage 5: recombine partial products
    logic signed [PROD_W-1:0] p_next;
    assign p_next = (PROD_W'(ph_s4_reg) <<< GL_W) + PROD_W'($signed({1'b0, pl_s4_reg}));

    // Stage 6: scale = 1 - term in Q2.30, saturated to 32 bits
    logic signed [PROD_W-11:0] term_c;
    logic signed [SFW-1:0]     scale_full;
    logic signed [31:0]        scale_next;

    always_comb
    begin
        term_c     = $signed(p_s5_reg[PROD_W-1:10]);
        scale_full = SC_ONE - SFW'(term_c);
        if (scale_full > SC_MAX)
            scale_next = 32'sh7FFF_FFFF;
        else if (scale_full < SC_MIN)
            scale_next = 32'sh8000_0000;
        else
            scale_next = 32'(scale_full);
    end

    // Stage 7: offset times scale
    logic signed [MXW-1:0] mx_next, my_next;
    assign mx_next = dx_pipe_reg[6] * scale_s6_reg;
    assign my_next = dy_pipe_reg[6] * scale_s6_reg;

    // Stage 8: source position with 16 fraction bits
    logic signed [SXW-1:0] sx_next, sy_next;
    assign sx_next = $signed((SXW'(w_eff) << 15) - (SXW'(1) << 15)
                     + SXW'($signed(mx_s7_reg[MXW-1:15])));
    assign sy_next = $signed((SXW'(h_eff) << 15) - (SXW'(1) << 15)
                     + SXW'($signed(my_s7_reg[MXW-1:15])));

    always_ff @(posedge clk)
    begin
        wr_pipe_reg[1] <= '{col: req.pixel_col, row: req.pixel_row, rgba: req.source_rgba};
        for (int k = 2; k <= 8; k++)
        begin
            wr_pipe_reg[k] <= wr_pipe_reg[k-1];
        end
        dx_pipe_reg[1] <= dx_next;
        dy_pipe_reg[1] <= dy_next;
        for (int k = 2; k <= 6; k++)
        begin
            dx_pipe_reg[k] <= dx_pipe_reg[k-1];
            dy_pipe_reg[k] <= dy_pipe_reg[k-1];
        end
        sqx_s2_reg   <= R2W'(sqx_full);
        sqy_s2_reg   <= R2W'(sqy_full);
        r2_s3_reg    <= sqx_s2_reg + sqy_s2_reg;
        pl_s4_reg    <= pl_next;
        ph_s4_reg    <= ph_next;
        p_s5_reg     <= p_next;
        scale_s6_reg <= scale_next;
        mx_s7_reg    <= mx_next;
        my_s7_reg    <= my_next;
        sx_s8_reg    <= sx_next;
        sy_s8_reg    <= sy_next;
    end

    // ---------------- stage 8: neighbor select and store access ----------------
    function automatic logic in_frame(input logic [XW-1:0] v, input logic [SW-1:0] lim);
        in_frame = !v[XW-1] && (v < XW'(lim));
    endfunction

    logic [XW-1:0]     x0, x1, y0, y1;
    logic [FRAC_W-1:0] fx, fy;
    logic [WT_W-1:0]   wx_c [2];
    logic [WT_W-1:0]   wy_c [2];
    logic [1:0]        okx_c, oky_c;
    logic [CAW-1:0]    rcol_addr [2];
    logic [RAW-1:0]    rrow_addr [2];

    always_comb
    begin
        x0 = sx_s8_reg[SXW-1:FRAC_W];
        y0 = sy_s8_reg[SXW-1:FRAC_W];
        x1 = x0 + XW'(1);
        y1 = y0 + XW'(1);
        fx = sx_s8_reg[FRAC_W-1:0];
        fy = sy_s8_reg[FRAC_W-1:0];
        // each parity bank takes whichever of the two neighbors has its parity
        for (int p = 0; p < 2; p++)
        begin
            if (x0[0] == p[0])
            begin
                wx_c[p]      = (WT_W'(1) << FRAC_W) - WT_W'(fx);
                okx_c[p]     = in_frame(x0, w_eff);
                rcol_addr[p] = x0[CAW:1];
            end
            else
            begin
                wx_c[p]      = WT_W'(fx);
                okx_c[p]     = in_frame(x1, w_eff);
                rcol_addr[p] = x1[CAW:1];
            end
            if (y0[0] == p[0])
            begin
                wy_c[p]      = (WT_W'(1) << FRAC_W) - WT_W'(fy);
                oky_c[p]     = in_frame(y0, h_eff);
                rrow_addr[p] = y0[RAW:1];
            end
            else
            begin
                wy_c[p]      = WT_W'(fy);
                oky_c[p]     = in_frame(y1, h_eff);
                rrow_addr[p] = y1[RAW:1];
            end
        end
    end

    // Write side: stores land at the same stage as reads, keeping request order
    logic [XW-1:0]  wcol, wrow;
    logic           wr_ok;
    logic [BAW-1:0] waddr;

    assign wcol  = XW'(wr_pipe_reg[8].col);
    assign wrow  = XW'(wr_pipe_reg[8].row);
    assign wr_ok = wr_vld_reg[8] && (32'(wr_pipe_reg[8].col) < MAX_WIDTH)
                   && (32'(wr_pipe_reg[8].row) < MAX_HEIGHT);
    assign waddr = {wrow[RAW:1], wcol[CAW:1]};

    logic [31:0] bank_rdata [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        rlwb_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (wr_ok && (wcol[0] == b[0]) && (wrow[0] == b[1])),
            .waddr (waddr),
            .wdata (wr_pipe_reg[8].rgba),
            .raddr ({rrow_addr[b/2], rcol_addr[b%2]}),
            .rdata (bank_rdata[b])
        );
    end

    // ---------------- stage 9: neighbor weights ----------------
    logic [WT_W-1:0] wx_s9_reg [2];
    logic [WT_W-1:0] wy_s9_reg [2];
    logic [1:0]      okx_s9_reg, oky_s9_reg;

    always_ff @(posedge clk)
    begin
        wx_s9_reg  <= wx_c;
        wy_s9_reg  <= wy_c;
        okx_s9_reg <= okx_c;
        oky_s9_reg <= oky_c;
    end

    logic [2*WT_W-1:0] wgt_full [4];
    logic [WGT_W-1:0]  wgt_c [4];

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            wgt_full[b] = wy_s9_reg[b/2] * wx_s9_reg[b%2];
            if (okx_s9_reg[b%2] && oky_s9_reg[b/2])
                wgt_c[b] = wgt_full[b][WGT_W-1:0];
            else
                wgt_c[b] = '0;
        end
    end

    // ---------------- stage 10: weight times channel ----------------
    logic [WGT_W-1:0] wgt_s10_reg [4];
    logic [31:0]      pix_s10_reg [4];
    logic             allok_s10_reg;

    always_ff @(posedge clk)
    begin
        wgt_s10_reg   <= wgt_c;
        pix_s10_reg   <= bank_rdata;
        allok_s10_reg <= (&okx_s9_reg) && (&oky_s9_reg);
    end

    logic [PRD_W-1:0] prod_c [4][4];

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_c[b][c] = wgt_s10_reg[b] * pix_s10_reg[b][8*c +: 8];
            end
        end
    end

    // ---------------- stage 11: sum and round half up ----------------
    logic [PRD_W-1:0] prod_s11_reg [4][4];

    always_ff @(posedge clk)
    begin
        prod_s11_reg <= prod_c;
    end

    logic [SUM_W-1:0] sum_c [4];
    logic [7:0]       chan_c [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_c[c] = SUM_W'(prod_s11_reg[0][c]) + SUM_W'(prod_s11_reg[1][c])
                     + SUM_W'(prod_s11_reg[2][c]) + SUM_W'(prod_s11_reg[3][c])
                     + (SUM_W'(1) << 31);
            chan_c[c] = sum_c[c][39:32];
        end
    end

    out_pix_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg <= '{chan3_value: chan_c[3], chan2_value: chan_c[2],
                        chan1_value: chan_c[1], chan0_value: chan_c[0]};
    end

    assign result = result_reg;

    // ---------------- assertions ----------------
    logic [WGT_W+1:0] wgt_total;
    assign wgt_total = (WGT_W+2)'(wgt_s10_reg[0]) + (WGT_W+2)'(wgt_s10_reg[1])
                     + (WGT_W+2)'(wgt_s10_reg[2]) + (WGT_W+2)'(wgt_s10_reg[3]);

    `RLWB_ASSERT(a_render_gives_result, start && !busy && req.req_type == REQ_RENDER |-> ##12 result_valid, "render request lost")
    `RLWB_ASSERT(a_result_has_render, result_valid |-> $past(start && !busy && req.req_type == REQ_RENDER, 12), "result without render request")
    `RLWB_ASSERT_ALWAYS(a_weights_unit_sum, rd_vld_reg[10] && allok_s10_reg |-> wgt_total == ((WGT_W+2)'(1) << 32), "bilinear weights do not sum to one")

endmodule

`default_nettype wire

// File: tb/radial_lens_warp_bilinear_tb.sv
// Self-checking testbench for radial_lens_warp_bilinear: before each render, writes any unwritten
// source pixel it reads; runs directed and random traffic under several frame and gain settings.
// Depends on rlwb_pkg and the radial_lens_warp_bilinear RTL.
`timescale 1ns / 1ps

module radial_lens_warp_bilinear_tb;
    import rlwb_pkg::*;

    localparam int  LAT_CYCLES  = 16;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  ITEM_TARGET = 650;
    localparam int  NUM_PHASES  = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Warp predictor and queue of expected pixels
    class warp_scoreboard;
        bit [31:0]   store [0:65535];
        bit          written [0:65535];
        longint      fw;
        longint      fh;
        longint      gain;
        out_pix_t    pix_q [$];
        int          errors;

        function new();
            fw = 256;
            fh = 256;
            gain = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            logic signed [GAIN_W-1:0] g;
            g = data;
            if (idx == CFG_FRAME_WIDTH)
                fw = data[SIZE_W-1:0];
            else if (idx == CFG_FRAME_HEIGHT)
                fh = data[SIZE_W-1:0];
            else if (idx == CFG_DISTORTION_GAIN)
                gain = g;
        endfunction

        // Source position (16 fraction bits) of a destination pixel, with effective frame size
        function void locate(logic [7:0] col, logic [7:0] row, output longint w,
                             output longint h, output longint sx, output longint sy);
            longint dx2, dy2, r2, term, scale;
            longint unsigned magg;
            w = (fw < 1) ? 1 : (fw > 256) ? 256 : fw;
            h = (fh < 1) ? 1 : (fh > 256) ? 256 : fh;
            dx2 = 2 * longint'(col) + 1 - w;
            dy2 = 2 * longint'(row) + 1 - h;
            r2 = dx2 * dx2 + dy2 * dy2;
            magg = (gain < 0) ? -gain : gain;
            // very large gain*r2 pins the term
            if (r2 != 0 && magg > (64'd1 << 62) / longint'(r2))
                term = (gain < 0) ? -(longint'(1) << 52) : (longint'(1) << 52);
            else
                term = (gain * r2) >>> 10;
            scale = (longint'(1) << 30) - term;
            if (scale > 64'sh7FFFFFFF)
                scale = 64'sh7FFFFFFF;
            if (scale < -(longint'(1) << 31))
                scale = -(longint'(1) << 31);
            sx = w * 32768 - 32768 + ((dx2 * scale) >>> 15);
            sy = h * 32768 - 32768 + ((dy2 * scale) >>> 15);
        endfunction

        // In-frame store entries a render would read that were never written
        function void unwritten_reads(logic [7:0] col, logic [7:0] row, ref int addrs [$]);
            longint w, h, sx, sy, x0, y0, ry, cx;
            addrs.delete();
            locate(col, row, w, h, sx, sy);
            x0 = sx >>> FRAC_W;
            y0 = sy >>> FRAC_W;
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 2; i++) begin
                    ry = y0 + j;
                    cx = x0 + i;
                    if (ry >= 0 && ry < h && cx >= 0 && cx < w && !written[ry * 256 + cx])
                        addrs.push_back(int'(ry * 256 + cx));
                end
            end
        endfunction

        // Accepted request: update the store or predict the rendered pixel
        function void note_input(in_req_t r);
            longint w, h, sx, sy, x0, y0, ry, cx;
            longint unsigned fx, fy, wy, wgt;
            longint unsigned sums [4];
            bit [31:0] px;
            out_pix_t p;
            if (r.req_type == REQ_WRITE) begin
                store[{r.pixel_row, r.pixel_col}] = r.source_rgba;
                written[{r.pixel_row, r.pixel_col}] = 1'b1;
                return;
            end
            locate(r.pixel_col, r.pixel_row, w, h, sx, sy);
            x0 = sx >>> FRAC_W;
            y0 = sy >>> FRAC_W;
            fx = sx & 64'hFFFF;
            fy = sy & 64'hFFFF;
            for (int c = 0; c < 4; c++)
                sums[c] = 0;
            // off-frame neighbors drop out, no renormalizing
            for (int j = 0; j < 2; j++) begin
                ry = y0 + j;
                wy = j ? fy : 65536 - fy;
                if (ry >= 0 && ry < h) begin
                    for (int i = 0; i < 2; i++) begin
                        cx = x0 + i;
                        wgt = wy * (i ? fx : 65536 - fx);
                        if (cx >= 0 && cx < w) begin
                            px = store[ry * 256 + cx];
                            for (int c = 0; c < 4; c++)
                                sums[c] += wgt * px[8*c +: 8];
                        end
                    end
                end
            end
            p.chan0_value = 8'((sums[0] + (64'd1 << 31)) >> 32);
            p.chan1_value = 8'((sums[1] + (64'd1 << 31)) >> 32);
            p.chan2_value = 8'((sums[2] + (64'd1 << 31)) >> 32);
            p.chan3_value = 8'((sums[3] + (64'd1 << 31)) >> 32);
            pix_q.push_back(p);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check(out_pix_t got);
            out_pix_t want;
            if (pix_q.size() == 0) begin
                report("unexpected pixel, chan0", got.chan0_value, -1);
                return;
            end
            want = pix_q.pop_front();
            if (got.chan0_value != want.chan0_value)
                report("chan0", got.chan0_value, want.chan0_value);
            if (got.chan1_value != want.chan1_value)
                report("chan1", got.chan1_value, want.chan1_value);
            if (got.chan2_value != want.chan2_value)
                report("chan2", got.chan2_value, want.chan2_value);
            if (got.chan3_value != want.chan3_value)
                report("chan3", got.chan3_value, want.chan3_value);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_req_t               req;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [GAIN_W-1:0]     cfg_data;
    logic                  result_valid;
    out_pix_t              result;

    warp_scoreboard sb;
    int cycles;
    int sent;

    radial_lens_warp_bilinear dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && result_valid)
            sb.check(result);
    end

    // Run guard
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Issue one request; start stays high for a following one
    task send(logic kind, logic [7:0] col, logic [7:0] row, logic [31:0] rgba);
        in_req_t r;
        r.req_type = kind;
        r.pixel_col = col;
        r.pixel_row = row;
        r.source_rgba = rgba;
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        sb.note_input(r);
        sent++;
    endtask

    // Render request, preceded by writes to any in-frame entry it would read unwritten
    task render(logic [7:0] col, logic [7:0] row, logic [31:0] rgba);
        int addrs [$];
        sb.unwritten_reads(col, row, addrs);
        foreach (addrs[i])
            send(REQ_WRITE, addrs[i][7:0], addrs[i][15:8], $urandom);
        send(REQ_RENDER, col, row, rgba);
    endtask

    task idle_gap(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function int rand_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return 0;
        if (sel < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 50);
    endfunction

    // Block idle: no request pending, nothing expected, pipeline flushed
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pix_q.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task configure(int w, int h, logic [GAIN_W-1:0] g);
        drain();
        cfg_write(CFG_FRAME_WIDTH, GAIN_W'(w));
        cfg_write(CFG_FRAME_HEIGHT, GAIN_W'(h));
        cfg_write(CFG_DISTORTION_GAIN, g);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function logic [GAIN_W-1:0] rand_gain(int w, int h);
        longint k;
        longint den;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return GAIN_W'({$urandom, $urandom});
        // k in about [-0.6, 0.6] scaled by 2^40 / (w^2 + h^2)
        k = longint'($urandom_range(0, 2400)) - 1200;
        den = longint'(w) * longint'(w) + longint'(h) * longint'(h);
        return GAIN_W'((k * (longint'(1) << 40) / 2000) / den);
    endfunction

    function logic [7:0] rand_coord(int lim);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, (lim > 256 ? 256 : (lim < 1 ? 1 : lim)) - 1));
    endfunction

    initial begin
        int w, h;
        int stop;
        sb = new();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity warp at corners and center, all-zero and all-ones pixels
        send(REQ_WRITE, 8'd0, 8'd0, 32'h0000_0000);
        send(REQ_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send(REQ_WRITE, 8'd128, 8'd127, 32'hA5C3_5A3C);
        render(8'd0, 8'd0, 32'hFFFF_FFFF);
        render(8'd255, 8'd255, 32'h0);
        render(8'd128, 8'd127, 32'h0);
        render(8'd0, 8'd255, 32'h0);
        // gain extremes saturate the scale
        configure(256, 256, {1'b0, {40{1'b1}}});
        render(8'd0, 8'd0, 32'h0);
        render(8'd255, 8'd0, 32'h0);
        render(8'd128, 8'd128, 32'h0);
        configure(256, 256, {1'b1, {40{1'b0}}});
        render(8'd0, 8'd0, 32'h0);
        render(8'd200, 8'd17, 32'h0);
        // zero and oversize frame registers clamp; renders outside the frame
        configure(0, 511, 41'd4096);
        render(8'd0, 8'd0, 32'h0);
        render(8'd255, 8'd255, 32'h0);
        configure(1, 1, '0);
        render(8'd0, 8'd0, 32'h0);
        render(8'd255, 8'd3, 32'h0);
        configure(3, 2, 41'h100_0000);
        render(8'd2, 8'd1, 32'h0);
        send(REQ_WRITE, 8'd250, 8'd250, 32'h1234_5678);
        render(8'd40, 8'd9, 32'h0);
        // unknown register index leaves settings alone
        drain();
        cfg_write(CFG_UNUSED, {GAIN_W{1'b1}});
        cfg_valid <= 1'b0;
        @(posedge clk);
        render(8'd1, 8'd0, 32'h0);

        // random phases, each under its own frame and gain setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin w = 256; h = 256; end
                1: begin w = 2; h = 1; end
                2: begin w = $urandom_range(0, 511); h = $urandom_range(0, 511); end
                default: begin w = $urandom_range(1, 256); h = $urandom_range(1, 256); end
            endcase
            configure(w, h, rand_gain(w < 1 ? 1 : w, h < 1 ? 1 : h));
            stop = sent + (ITEM_TARGET - sent) / (NUM_PHASES - ph);
            while (sent < stop) begin
                if ($urandom_range(0, 9) < 4)
                    send(REQ_WRITE, 8'($urandom), 8'($urandom), $urandom);
                else
                    render(rand_coord(w), rand_coord(h), $urandom);
                idle_gap(rand_gap());
            end
        end

        drain();
        if (sb.errors == 0 && sb.pix_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
